@@ rtl/core/dta_pkg.sv @@
// ----------------------------------------------------------------------------
// dta_pkg
// Shared constants and types of the down-counter time accumulator.
// ----------------------------------------------------------------------------
package dta_pkg;

  localparam int unsigned CntW    = 24;  // counter sample / reload width
  localparam int unsigned TicksPerUs = 3;
  localparam int unsigned UsPerMs = 1000;

  localparam logic [CntW-1:0] ReloadRst = 24'd5999999;

  // floor(x/3) = (x * ceil(2^26/3)) >> 26, exact for x < 2^25
  localparam int unsigned    Div3Shift = 26;
  localparam logic [24:0]    Div3Mult  = 25'd22369622;
  // floor(x/1000) = (x * ceil(2^33/1000)) >> 33, exact for x < 2^24
  localparam int unsigned    Div1kShift = 33;
  localparam logic [23:0]    Div1kMult  = 24'd8589935;

  localparam int unsigned QbW = 23;  // ticks / 3
  localparam int unsigned QmW = 14;  // (ticks / 3) / 1000
  localparam int unsigned RmW = 10;  // (ticks / 3) % 1000
  localparam int unsigned RbW = 2;   // ticks % 3

  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = 3;
  localparam int unsigned FifoCntW  = 4;

  // One classified sample: ticks split into whole us and ms parts
  typedef struct packed {
    logic [QbW-1:0] qb;  // whole microseconds of this step
    logic [RbW-1:0] rb;  // leftover ticks of this step
    logic [QmW-1:0] qm;  // whole milliseconds of qb
    logic [RmW-1:0] rm;  // leftover microseconds of qb
  } dta_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dta_fifo_st_t;

endpackage

@@ rtl/core/downcounter_time_accumulator.sv @@
// ----------------------------------------------------------------------------
// downcounter_time_accumulator
// Microsecond / millisecond timebase from samples of a 24-bit down-counter.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output side accepts; the 4-stage
//   front pipeline plus the 8-entry queue cover the credit round trip.
// Reset: async active low; totals, carries and previous sample clear to 0,
//   reload register comes up at 5999999.
module downcounter_time_accumulator import dta_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,    // reload_value
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // [23:0] count_sample
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [63:0]     m_axis_tdata    // [31:0] micros_total, [63:32] millis_total
);

  logic         push;
  dta_item_t    push_item;
  logic         fifo_valid;
  dta_item_t    fifo_item;
  dta_fifo_st_t fifo_st;
  logic         pop;
  logic [31:0]  micros;
  logic [31:0]  millis;

  // Front: elapsed ticks (wrap through reload), then /3 and /1000 splits.
  // Admission is credit based, so the queue can never overflow.
  dta_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_sample_i  (s_axis_tdata[CntW-1:0]),
    .credit_ret_i (pop),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  dta_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .item_o      (fifo_item),
    .status_o    (fifo_st)
  );

  // Back: tick and microsecond carries fold in with one compare/subtract
  // each; the output register decouples it from the downstream side.
  dta_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_item_i  (fifo_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .micros_o     (micros),
    .millis_o     (millis)
  );

  assign m_axis_tdata = {millis, micros};

`ifndef NO_ASSERTIONS
  // credits keep the front from pushing into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && fifo_st.full) |-> pop)
    else $error("queue overflow");

  // a new result only shows up after a queue entry was consumed
  a_result_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(pop))
    else $error("result beat without a queue pop");

  // nothing is popped from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_st.empty |-> !pop)
    else $error("queue underflow");
`endif

endmodule

@@ rtl/core/dta_front.sv @@
// ----------------------------------------------------------------------------
// dta_front
// Accepts counter samples, derives elapsed ticks and splits them into
// microsecond and millisecond parts over a short pipeline.
// ----------------------------------------------------------------------------
module dta_front import dta_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CntW-1:0] in_sample_i,
  input  logic            credit_ret_i,  // one queue slot freed
  output logic            push_o,
  output dta_item_t       push_item_o
);

  logic [CntW-1:0]     reload_q;
  logic [CntW-1:0]     prev_q;
  logic [FifoCntW-1:0] credit_q, credit_d;
  logic                accept;

  logic            s0_valid_q, s1_valid_q, s2_valid_q, s3_valid_q;
  logic [CntW-1:0] s0_ticks_q, s0_ticks_d;
  logic [CntW-1:0] s1_ticks_q;
  logic [QbW-1:0]  s1_qb_q, s2_qb_q;
  logic [RbW-1:0]  s2_rb_q;
  logic [QmW-1:0]  s2_qm_q;
  dta_item_t       s3_item_q;

  logic [48:0]     prod3;
  logic [46:0]     prod1k;
  logic [CntW-1:0] qb_x3;
  logic [CntW-1:0] qm_x1k;
  logic [CntW:0]   wrap_sum;

  assign in_ready_o = (credit_q != '0);
  assign accept     = in_valid_i & in_ready_o;

  // equal sample counts as a wrap; reload below sample adds nothing
  always_comb begin
    wrap_sum = {1'b0, prev_q};
    if (reload_q > in_sample_i) begin
      wrap_sum = {1'b0, prev_q} + {1'b0, reload_q} - {1'b0, in_sample_i};
    end
    if (in_sample_i < prev_q) begin
      s0_ticks_d = prev_q - in_sample_i;
    end else begin
      s0_ticks_d = wrap_sum[CntW-1:0];  // at most the larger of reload and sample
    end
  end

  assign prod3  = 49'(s0_ticks_q) * 49'(Div3Mult);
  assign qb_x3  = CntW'(s1_qb_q) * CntW'(TicksPerUs);
  assign prod1k = 47'(s1_qb_q) * 47'(Div1kMult);
  assign qm_x1k = CntW'(s2_qm_q) * CntW'(UsPerMs);

  always_comb begin
    credit_d = credit_q;
    case ({accept, credit_ret_i})
      2'b10:   credit_d = credit_q - FifoCntW'(1);
      2'b01:   credit_d = credit_q + FifoCntW'(1);
      default: credit_d = credit_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q   <= ReloadRst;
      prev_q     <= '0;
      credit_q   <= FifoCntW'(FifoDepth);
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        reload_q <= cfg_wdata_i;
      end
      if (accept) begin
        prev_q <= in_sample_i;
      end
      credit_q   <= credit_d;
      s0_valid_q <= accept;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    s0_ticks_q      <= s0_ticks_d;
    s1_ticks_q      <= s0_ticks_q;
    s1_qb_q         <= prod3[Div3Shift +: QbW];
    s2_qb_q         <= s1_qb_q;
    s2_rb_q         <= RbW'(s1_ticks_q - qb_x3);
    s2_qm_q         <= prod1k[Div1kShift +: QmW];
    s3_item_q.qb    <= s2_qb_q;
    s3_item_q.rb    <= s2_rb_q;
    s3_item_q.qm    <= s2_qm_q;
    s3_item_q.rm    <= RmW'(CntW'(s2_qb_q) - qm_x1k);
  end

  assign push_o      = s3_valid_q;
  assign push_item_o = s3_item_q;

endmodule

@@ rtl/core/dta_fifo.sv @@
// ----------------------------------------------------------------------------
// dta_fifo
// Small queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module dta_fifo import dta_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  dta_item_t    push_item_i,
  input  logic         pop_i,
  output logic         valid_o,
  output dta_item_t    item_o,
  output dta_fifo_st_t status_o
);

  dta_item_t           mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] count_q;

  assign valid_o         = (count_q != '0);
  assign item_o          = mem_q[rd_ptr_q];
  assign status_o.empty  = (count_q == '0);
  assign status_o.full   = (count_q == FifoCntW'(FifoDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + FifoCntW'(1);
        2'b01:   count_q <= count_q - FifoCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/core/dta_back.sv @@
// ----------------------------------------------------------------------------
// dta_back
// Folds carries into each classified sample and advances the totals.
// ----------------------------------------------------------------------------
module dta_back import dta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fifo_valid_i,
  input  dta_item_t   fifo_item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] micros_o,
  output logic [31:0] millis_o
);

  logic [RbW-1:0] tick_carry_q, tick_carry_d;
  logic [RmW-1:0] micro_carry_q, micro_carry_d;
  logic [31:0]    micro_sum_q, micro_sum_d;
  logic [31:0]    milli_sum_q, milli_sum_d;
  logic           out_valid_q;
  logic [2:0]     tick_sum;
  logic           us_inc;
  logic [RmW:0]   us_rem;
  logic           ms_inc;

  assign pop_o = fifo_valid_i & (~out_valid_q | out_ready_i);

  always_comb begin
    tick_sum     = 3'(fifo_item_i.rb) + 3'(tick_carry_q);  // < 2*3
    us_inc       = (tick_sum >= 3'(TicksPerUs));
    tick_carry_d = us_inc ? RbW'(tick_sum - 3'(TicksPerUs)) : RbW'(tick_sum);
    micro_sum_d  = micro_sum_q + 32'(fifo_item_i.qb) + 32'(us_inc);

    us_rem        = (RmW+1)'(fifo_item_i.rm) + (RmW+1)'(micro_carry_q)
                  + (RmW+1)'(us_inc);                     // < 2*1000
    ms_inc        = (us_rem >= (RmW+1)'(UsPerMs));
    micro_carry_d = ms_inc ? RmW'(us_rem - (RmW+1)'(UsPerMs)) : RmW'(us_rem);
    milli_sum_d   = milli_sum_q + 32'(fifo_item_i.qm) + 32'(ms_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_carry_q  <= '0;
      micro_carry_q <= '0;
      micro_sum_q   <= '0;
      milli_sum_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        tick_carry_q  <= tick_carry_d;
        micro_carry_q <= micro_carry_d;
        micro_sum_q   <= micro_sum_d;
        milli_sum_q   <= milli_sum_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign micros_o    = micro_sum_q;
  assign millis_o    = milli_sum_q;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the down-counter time accumulator: feeds counter
// samples (directed corners, then down-counting runs mixed with noise) under
// several reload settings and handshake idling profiles, and compares every
// result beat with microsecond and millisecond totals predicted in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import dta_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumPhases   = 6;
  localparam int unsigned RandPerPhase = 100;
  localparam int unsigned LongHold    = 300;  // receiver hold-off, in cycles
  localparam int unsigned DrainCycles = 20;   // settle time before the final verdict

  typedef logic [CntW-1:0] count_t;

  // --------------------------------------------------------------------------
  // Expected totals: own copy of the timebase state, one entry per sample beat
  // --------------------------------------------------------------------------
  class timebase_scoreboard;
    count_t      reload;
    count_t      last_count;
    logic [1:0]  tick_rem;   // ticks short of a whole microsecond
    logic [9:0]  us_rem;     // microseconds short of a whole millisecond
    logic [31:0] us_total;
    logic [31:0] ms_total;
    logic [63:0] totals_q[$];  // {millis, micros} per accepted sample
    int unsigned errors;

    function new();
      reload     = ReloadRst;
      last_count = '0;
      tick_rem   = '0;
      us_rem     = '0;
      us_total   = '0;
      ms_total   = '0;
      errors     = 0;
    endfunction

    function void set_reload(count_t v);
      reload = v;
    endfunction

    function int unsigned pending();
      return totals_q.size();
    endfunction

    function void note_sample(count_t s);
      logic [63:0] ticks;
      logic [63:0] us_step;
      logic [63:0] us_all;
      // a sample at or above the previous one means the counter reloaded;
      // above the reload value only the previous sample is credited
      if (s < last_count) begin
        ticks = 64'(last_count) - 64'(s);
      end else begin
        ticks = 64'(last_count);
        if (reload > s) ticks = ticks + 64'(reload) - 64'(s);
      end
      last_count = s;
      ticks      = ticks + 64'(tick_rem);
      us_step    = ticks / TicksPerUs;
      tick_rem   = 2'(ticks % TicksPerUs);
      us_total   = us_total + us_step[31:0];
      us_all     = us_step + 64'(us_rem);
      ms_total   = ms_total + 32'(us_all / UsPerMs);
      us_rem     = 10'(us_all % UsPerMs);
      totals_q.push_back({ms_total, us_total});
    endfunction

    function void check_totals(logic [63:0] got);
      logic [63:0] exp_totals;
      if (totals_q.size() == 0) begin
        $display("%0t: unexpected result beat, micros=%0d millis=%0d",
                 $realtime, got[31:0], got[63:32]);
        errors++;
        return;
      end
      exp_totals = totals_q.pop_front();
      if (got[31:0] !== exp_totals[31:0]) begin
        $display("%0t: micros_total mismatch, expected %0d, actual %0d",
                 $realtime, exp_totals[31:0], got[31:0]);
        errors++;
      end
      if (got[63:32] !== exp_totals[63:32]) begin
        $display("%0t: millis_total mismatch, expected %0d, actual %0d",
                 $realtime, exp_totals[63:32], got[63:32]);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  count_t      cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [23:0] count_sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [31:0] micros_total, [63:32] millis_total

  downcounter_time_accumulator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  timebase_scoreboard sb = new();

  // idling profile, percent of cycles with no offer / no accept
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  // long hold-off requests: receiver serves one per increment
  int unsigned hold_req_cnt = 0;

  // bench's view of the counter, used to shape down-counting runs
  count_t      reload_now = ReloadRst;
  count_t      last_sent  = '0;

  // --------------------------------------------------------------------------
  // Monitors: both beat directions seen at the same edge, input side first
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_totals(m_axis_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random backpressure plus a single long hold-off, which
  // lets the pipeline and output queue fill so the input stalls too
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_req_cnt) begin
        holds_served = hold_req_cnt;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks; all are entered and left at a rising edge
  // --------------------------------------------------------------------------
  // one sample beat, with random idle cycles in front of it
  task automatic send_sample(input count_t v);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    last_sent      = v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // only called with nothing in flight
  task automatic write_reload(input count_t v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reload_now   = v;
    sb.set_reload(v);
  endtask

  // drop valid, let the last beat register, then wait for every result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly a believable down-counter: small or large steps, wrapping through
  // the reload value. Some repeats of the last sample (taken as a full wrap)
  // and some raw noise, which also reaches values above the reload.
  function automatic count_t next_count();
    int unsigned pick;
    longint      dec;
    longint      val;
    pick = $urandom_range(99);
    if (pick < 10) return last_sent;
    if (pick < 22) return count_t'($urandom_range(32'hFF_FFFF));
    if ($urandom_range(99) < 70) dec = $urandom_range(5000, 1);
    else dec = $urandom_range(reload_now, 1);
    val = longint'(last_sent) - dec;
    if (val < 0) val = longint'(reload_now) + val;
    if (val < 0) val = 0;
    return count_t'(val);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    count_t corner_counts[$];
    count_t reload_by_phase[NumPhases];

    // reset-default, then the largest reload and 1, random values and a small value
    reload_by_phase[0] = ReloadRst;
    reload_by_phase[1] = 24'hFF_FFFF;
    reload_by_phase[2] = 24'd1;
    reload_by_phase[3] = count_t'($urandom_range(32'hFF_FFFF, 1));
    reload_by_phase[4] = 24'd2999;
    reload_by_phase[5] = count_t'($urandom_range(32'hFF_FFFF, 1));

    // corners at the reset reload, starting from previous sample 0:
    // equal samples (full wrap), sample equal to reload, samples above the
    // reload (only the previous sample credited), one-tick steps, the
    // biggest single steps and alternating bit patterns
    corner_counts = '{24'd0, 24'd0, 24'd5999998, 24'd5999999, 24'hFF_FFFF,
                      24'hFF_FFFF, 24'd0, 24'd1, 24'd2, 24'd3000, 24'd2997,
                      24'd1, 24'd0, 24'hAA_AAAA, 24'h55_5555, 24'd5999999,
                      24'd3, 24'd2, 24'd6000000, 24'd1};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      // idling: sender light / receiver heavy, then swapped, then none
      if (ph < 2) begin
        tx_idle_pct = 14;
        rx_idle_pct = 77;
      end else if (ph < 4) begin
        tx_idle_pct = 77;
        rx_idle_pct = 14;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if (ph > 0) write_reload(reload_by_phase[ph]);

      if (ph == 0) begin
        foreach (corner_counts[i]) send_sample(corner_counts[i]);
      end

      // back up the output on the last, idle-free phase
      if (ph == NumPhases - 1) hold_req_cnt++;

      for (int n = 0; n < RandPerPhase; n++) send_sample(next_count());

      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
